// ===== sv/ptgc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the pixel to grid cell projector.
// Holds the register indexes, datapath widths and the configuration struct.
// No dependencies.
package ptgc_pkg;

    localparam int COL_W = 10;
    localparam int ROW_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SCALE_W = 24;
    localparam int TRIG_W = 16;
    localparam int OFS_W = 24;
    localparam int GRID_W = 13;
    localparam int INDEX_W = 24;
    localparam int CELL_W = 16;

    // Pixel offsets from the region edge; covers region sizes up to 4096.
    localparam int PX_W = 14;
    // trig times pixel offset
    localparam int MUL1_W = TRIG_W + PX_W;
    // times the zero-extended scale
    localparam int MUL2_W = MUL1_W + SCALE_W + 1;
    // Q.30 ground coordinate with headroom for the sum of two products
    localparam int FRAC_W = 30;
    localparam int GSUM_W = MUL2_W + 1;
    localparam int RND_W = GSUM_W - FRAC_W;
    localparam int OFS_SHIFT = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_FORWARD = 3'd0,
        REG_SCALE_SIDE    = 3'd1,
        REG_COS_YAW       = 3'd2,
        REG_SIN_YAW       = 3'd3,
        REG_OFFSET_X      = 3'd4,
        REG_OFFSET_Y      = 3'd5,
        REG_GRID_WIDTH    = 3'd6,
        REG_GRID_HEIGHT   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic        [SCALE_W-1:0] scale_forward;
        logic        [SCALE_W-1:0] scale_side;
        logic signed [TRIG_W-1:0]  cos_yaw;
        logic signed [TRIG_W-1:0]  sin_yaw;
        logic signed [OFS_W-1:0]   offset_x;
        logic signed [OFS_W-1:0]   offset_y;
        logic        [GRID_W-1:0]  grid_width;
        logic        [GRID_W-1:0]  grid_height;
    } cfg_t;

endpackage

// ===== sv/ptgc_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file of the pixel to grid cell projector.
// Depends on ptgc_pkg.
module ptgc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ptgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptgc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output ptgc_pkg::cfg_t                      cfg
);
    import ptgc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SCALE_FORWARD: cfg_next.scale_forward = cfg_wdata[SCALE_W-1:0];
                REG_SCALE_SIDE:    cfg_next.scale_side = cfg_wdata[SCALE_W-1:0];
                REG_COS_YAW:       cfg_next.cos_yaw = $signed(cfg_wdata[TRIG_W-1:0]);
                REG_SIN_YAW:       cfg_next.sin_yaw = $signed(cfg_wdata[TRIG_W-1:0]);
                REG_OFFSET_X:      cfg_next.offset_x = $signed(cfg_wdata[OFS_W-1:0]);
                REG_OFFSET_Y:      cfg_next.offset_y = $signed(cfg_wdata[OFS_W-1:0]);
                REG_GRID_WIDTH:    cfg_next.grid_width = cfg_wdata[GRID_W-1:0];
                REG_GRID_HEIGHT:   cfg_next.grid_height = cfg_wdata[GRID_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_forward <= '0;
            cfg_reg.scale_side    <= '0;
            cfg_reg.cos_yaw       <= TRIG_W'(16384);
            cfg_reg.sin_yaw       <= '0;
            cfg_reg.offset_x      <= '0;
            cfg_reg.offset_y      <= '0;
            cfg_reg.grid_width    <= GRID_W'(1);
            cfg_reg.grid_height   <= GRID_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/ptgc_rotate.sv =====
`timescale 1ns / 1ps
// Projection and rotation stages: pixel offsets, trig products, scale products
// and the Q.30 sum with the pose offset. Three register stages. Depends on ptgc_pkg.
module ptgc_rotate #(
    parameter int ROI_WIDTH  = 640,
    parameter int ROI_HEIGHT = 480
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptgc_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    input  logic [ptgc_pkg::COL_W-1:0]          pixel_col,
    input  logic [ptgc_pkg::ROW_W-1:0]          pixel_row,
    output logic                                out_valid,
    output logic signed [ptgc_pkg::GSUM_W-1:0]  gx,
    output logic signed [ptgc_pkg::GSUM_W-1:0]  gy
);
    import ptgc_pkg::*;

    localparam logic signed [PX_W-1:0] ROI_H_C = PX_W'(ROI_HEIGHT);
    localparam logic signed [PX_W-1:0] ROI_HALF_C = PX_W'(ROI_WIDTH / 2);

    logic signed [PX_W-1:0]   fwd_px;
    logic signed [PX_W-1:0]   side_px;
    logic signed [SCALE_W:0]  sf_s;
    logic signed [SCALE_W:0]  ss_s;

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [MUL1_W-1:0] cf_reg, ss1_reg, sf1_reg, cs_reg;
    logic signed [MUL1_W-1:0] cf_next, ss1_next, sf1_next, cs_next;
    logic signed [MUL2_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [MUL2_W-1:0] a_next, b_next, c_next, d_next;
    logic signed [GSUM_W-1:0] gx_reg, gy_reg;
    logic signed [GSUM_W-1:0] gx_next, gy_next;

    always_comb
    begin
        fwd_px  = ROI_H_C - $signed({{(PX_W-ROW_W){1'b0}}, pixel_row});
        side_px = $signed({{(PX_W-COL_W){1'b0}}, pixel_col}) - ROI_HALF_C;
        cf_next  = cfg.cos_yaw * fwd_px;
        ss1_next = cfg.sin_yaw * side_px;
        sf1_next = cfg.sin_yaw * fwd_px;
        cs_next  = cfg.cos_yaw * side_px;

        sf_s = $signed({1'b0, cfg.scale_forward});
        ss_s = $signed({1'b0, cfg.scale_side});
        a_next = cf_reg * sf_s;
        b_next = ss1_reg * ss_s;
        c_next = sf1_reg * sf_s;
        d_next = cs_reg * ss_s;

        // Offsets are Q16.8; shifting by 22 brings them to Q.30.
        gx_next = {a_reg[MUL2_W-1], a_reg} - {b_reg[MUL2_W-1], b_reg}
                + {{(GSUM_W-OFS_W-OFS_SHIFT){cfg.offset_x[OFS_W-1]}},
                   cfg.offset_x, {OFS_SHIFT{1'b0}}};
        gy_next = {c_reg[MUL2_W-1], c_reg} + {d_reg[MUL2_W-1], d_reg}
                + {{(GSUM_W-OFS_W-OFS_SHIFT){cfg.offset_y[OFS_W-1]}},
                   cfg.offset_y, {OFS_SHIFT{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cf_reg  <= cf_next;
        ss1_reg <= ss1_next;
        sf1_reg <= sf1_next;
        cs_reg  <= cs_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
    end

    assign out_valid = v3_reg;
    assign gx = gx_reg;
    assign gy = gy_reg;

endmodule

// ===== sv/ptgc_quant.sv =====
`timescale 1ns / 1ps
// Rounding, saturation, grid bounds check and flat index: two register stages.
// Depends on ptgc_pkg.
module ptgc_quant (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptgc_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    input  logic signed [ptgc_pkg::GSUM_W-1:0]  gx,
    input  logic signed [ptgc_pkg::GSUM_W-1:0]  gy,
    output logic                                out_valid,
    output logic [ptgc_pkg::INDEX_W-1:0]        cell_index,
    output logic                                in_bounds,
    output logic signed [ptgc_pkg::CELL_W-1:0]  cell_forward,
    output logic signed [ptgc_pkg::CELL_W-1:0]  cell_lateral
);
    import ptgc_pkg::*;

    localparam logic signed [RND_W-1:0] CELL_MAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] CELL_MIN = -RND_W'(32768);
    localparam logic [GSUM_W-1:0] HALF = GSUM_W'(1) << (FRAC_W - 1);

    // Half away from zero: add one half, or one half less one LSB for negative
    // values, then shift arithmetically.
    function automatic logic signed [CELL_W-1:0] round_sat(logic signed [GSUM_W-1:0] v);
        logic signed [GSUM_W-1:0] t;
        logic signed [RND_W-1:0]  r;
        t = v + $signed(HALF - GSUM_W'(v[GSUM_W-1]));
        r = t[GSUM_W-1:FRAC_W];
        if (r > CELL_MAX)
            r = CELL_MAX;
        else if (r < CELL_MIN)
            r = CELL_MIN;
        return r[CELL_W-1:0];
    endfunction

    logic                     v4_reg, v5_reg;
    logic signed [CELL_W-1:0] cf_reg, cl_reg, cf_next, cl_next;
    logic signed [CELL_W-1:0] fwd_out_reg, lat_out_reg;
    logic [INDEX_W-1:0]       index_reg, index_next;
    logic                     ok_reg, ok_next;
    logic [2*GRID_W-1:0]      row_base;
    logic [2*GRID_W-1:0]      flat;

    always_comb
    begin
        cf_next = round_sat(gx);
        cl_next = round_sat(gy);

        ok_next = !cf_reg[CELL_W-1] && !cl_reg[CELL_W-1]
                && ({1'b0, cf_reg[CELL_W-2:0]} < CELL_W'(cfg.grid_height))
                && ({1'b0, cl_reg[CELL_W-2:0]} < CELL_W'(cfg.grid_width));
        // Inside the grid both coordinates fit in the grid field width.
        row_base = cf_reg[GRID_W-1:0] * cfg.grid_width;
        flat = row_base + {{GRID_W{1'b0}}, cl_reg[GRID_W-1:0]};
        index_next = ok_next ? flat[INDEX_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cf_reg      <= cf_next;
        cl_reg      <= cl_next;
        ok_reg      <= ok_next;
        index_reg   <= index_next;
        fwd_out_reg <= cf_reg;
        lat_out_reg <= cl_reg;
    end

    assign out_valid    = v5_reg;
    assign cell_index   = index_reg;
    assign in_bounds    = ok_reg;
    assign cell_forward = fwd_out_reg;
    assign cell_lateral = lat_out_reg;

endmodule

// ===== sv/pixel_to_grid_cell_projector.sv =====
`timescale 1ns / 1ps
// Pixel to grid cell projector, top level. Depends on ptgc_pkg, ptgc_cfg,
// ptgc_rotate and ptgc_quant.
// Pipeline: start passes through five register stages, in ptgc_rotate and then ptgc_quant,
// before done rises; the result is valid in the same cycle as done.
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// Reset: rst_n clears the pipeline valid bits and loads the register reset values.
module pixel_to_grid_cell_projector #(
    parameter int ROI_WIDTH  = 640,
    parameter int ROI_HEIGHT = 480
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ptgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptgc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [ptgc_pkg::COL_W-1:0]          pixel_col,
    input  logic [ptgc_pkg::ROW_W-1:0]          pixel_row,
    output logic                                done,
    output logic [ptgc_pkg::INDEX_W-1:0]        cell_index,
    output logic                                in_bounds,
    output logic signed [ptgc_pkg::CELL_W-1:0]  cell_forward,
    output logic signed [ptgc_pkg::CELL_W-1:0]  cell_lateral
);
    import ptgc_pkg::*;

    cfg_t                     cfg;
    logic                     rot_valid;
    logic signed [GSUM_W-1:0] gx;
    logic signed [GSUM_W-1:0] gy;

    // The pipeline never stalls, so a new transaction is taken every cycle.
    assign busy = 1'b0;

    ptgc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ptgc_rotate #(
        .ROI_WIDTH  (ROI_WIDTH),
        .ROI_HEIGHT (ROI_HEIGHT)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (start && !busy),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .out_valid (rot_valid),
        .gx        (gx),
        .gy        (gy)
    );

    ptgc_quant u_quant (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (rot_valid),
        .gx           (gx),
        .gy           (gy),
        .out_valid    (done),
        .cell_index   (cell_index),
        .in_bounds    (in_bounds),
        .cell_forward (cell_forward),
        .cell_lateral (cell_lateral)
    );

endmodule

// ===== tb/sv/cell_projection_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the pixel to grid cell projector: mirrors the register file,
// predicts the grid cell of every accepted pixel and compares each strobed result.
// Depends on ptgc_pkg.
module cell_projection_checker #(
    parameter int ROI_WIDTH  = 640,
    parameter int ROI_HEIGHT = 480
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ptgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptgc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                start,
    input  logic                                busy,
    input  logic [ptgc_pkg::COL_W-1:0]          pixel_col,
    input  logic [ptgc_pkg::ROW_W-1:0]          pixel_row,
    input  logic                                done,
    input  logic [ptgc_pkg::INDEX_W-1:0]        cell_index,
    input  logic                                in_bounds,
    input  logic signed [ptgc_pkg::CELL_W-1:0]  cell_forward,
    input  logic signed [ptgc_pkg::CELL_W-1:0]  cell_lateral,
    output int                                  fail_count,
    output int                                  pending
);
    import ptgc_pkg::*;

    // Ground coordinates carry 30 fractional bits before rounding to cells.
    localparam int GROUND_FRAC = 30;

    typedef struct packed {
        logic [INDEX_W-1:0]        index;
        logic                      in_bounds;
        logic signed [CELL_W-1:0]  forward;
        logic signed [CELL_W-1:0]  lateral;
    } grid_cell_t;

    cfg_t       settings;
    grid_cell_t predicted_cells[$];
    grid_cell_t oldest_cell;

    // Half away from zero on the magnitude, then clamp to the signed 16-bit range.
    function automatic logic signed [CELL_W-1:0] round_to_cell(input longint ground);
        longint mag;
        mag = (ground < 0) ? -ground : ground;
        mag = (mag + (longint'(1) << (GROUND_FRAC - 1))) >> GROUND_FRAC;
        if (mag > 32768)
            mag = 32768;
        if (ground < 0)
            mag = -mag;
        if (mag > 32767)
            mag = 32767;
        return mag[CELL_W-1:0];
    endfunction

    function automatic grid_cell_t project_pixel(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
        longint fwd;
        longint side;
        longint gx;
        longint gy;
        int f;
        int l;
        int gw;
        int gh;
        grid_cell_t proj;
        fwd  = (longint'(ROI_HEIGHT) - longint'(row)) * longint'(settings.scale_forward);
        side = (longint'(col) - longint'(ROI_WIDTH / 2)) * longint'(settings.scale_side);
        gx = longint'(settings.cos_yaw) * fwd - longint'(settings.sin_yaw) * side
             + longint'(settings.offset_x) * (longint'(1) << 22);
        gy = longint'(settings.sin_yaw) * fwd + longint'(settings.cos_yaw) * side
             + longint'(settings.offset_y) * (longint'(1) << 22);
        proj.forward = round_to_cell(gx);
        proj.lateral = round_to_cell(gy);
        f  = proj.forward;
        l  = proj.lateral;
        gw = settings.grid_width;
        gh = settings.grid_height;
        proj.in_bounds = (f >= 0) && (l >= 0) && (f < gh) && (l < gw);
        proj.index = proj.in_bounds ? INDEX_W'(l + f * gw) : '0;
        return proj;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            settings.scale_forward = '0;
            settings.scale_side    = '0;
            settings.cos_yaw       = 16'sd16384;
            settings.sin_yaw       = '0;
            settings.offset_x      = '0;
            settings.offset_y      = '0;
            settings.grid_width    = 13'd1;
            settings.grid_height   = 13'd1;
            predicted_cells.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (predicted_cells.size() == 0)
                begin
                    $error("result strobed with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest_cell = predicted_cells.pop_front();
                    if (cell_index !== oldest_cell.index)
                    begin
                        $error("cell_index mismatch: expected %0d, got %0d",
                               oldest_cell.index, cell_index);
                        fail_count++;
                    end
                    if (in_bounds !== oldest_cell.in_bounds)
                    begin
                        $error("in_bounds mismatch: expected %0d, got %0d",
                               oldest_cell.in_bounds, in_bounds);
                        fail_count++;
                    end
                    if (cell_forward !== oldest_cell.forward)
                    begin
                        $error("cell_forward mismatch: expected %0d, got %0d",
                               oldest_cell.forward, cell_forward);
                        fail_count++;
                    end
                    if (cell_lateral !== oldest_cell.lateral)
                    begin
                        $error("cell_lateral mismatch: expected %0d, got %0d",
                               oldest_cell.lateral, cell_lateral);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                predicted_cells = {predicted_cells, project_pixel(pixel_col, pixel_row)};
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_SCALE_FORWARD: settings.scale_forward = cfg_wdata;
                    REG_SCALE_SIDE:    settings.scale_side    = cfg_wdata;
                    REG_COS_YAW:       settings.cos_yaw       = cfg_wdata[TRIG_W-1:0];
                    REG_SIN_YAW:       settings.sin_yaw       = cfg_wdata[TRIG_W-1:0];
                    REG_OFFSET_X:      settings.offset_x      = cfg_wdata;
                    REG_OFFSET_Y:      settings.offset_y      = cfg_wdata;
                    REG_GRID_WIDTH:    settings.grid_width    = cfg_wdata[GRID_W-1:0];
                    REG_GRID_HEIGHT:   settings.grid_height   = cfg_wdata[GRID_W-1:0];
                    default: ;
                endcase
            end
            pending = predicted_cells.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the pixel to grid cell projector testbench: clock, reset, register
// programming and pixel stimulus. Depends on ptgc_pkg and cell_projection_checker.
module testbench;
    import ptgc_pkg::*;

    localparam int ROI_W          = 640;
    localparam int ROI_H          = 480;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_PIXELS   = 130;
    localparam int MAX_GAP        = 40;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_wdata;
    logic                      start;
    logic                      busy;
    logic [COL_W-1:0]          pixel_col;
    logic [ROW_W-1:0]          pixel_row;
    logic                      done;
    logic [INDEX_W-1:0]        cell_index;
    logic                      in_bounds;
    logic signed [CELL_W-1:0]  cell_forward;
    logic signed [CELL_W-1:0]  cell_lateral;

    int fail_count;
    int pending;
    int idle_pct;
    int stall_cycles;

    pixel_to_grid_cell_projector #(
        .ROI_WIDTH  (ROI_W),
        .ROI_HEIGHT (ROI_H)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .done         (done),
        .cell_index   (cell_index),
        .in_bounds    (in_bounds),
        .cell_forward (cell_forward),
        .cell_lateral (cell_lateral)
    );

    cell_projection_checker #(
        .ROI_WIDTH  (ROI_W),
        .ROI_HEIGHT (ROI_H)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .done         (done),
        .cell_index   (cell_index),
        .in_bounds    (in_bounds),
        .cell_forward (cell_forward),
        .cell_lateral (cell_lateral),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #2 clk = ~clk;

    // All drive tasks are entered and left just after a falling edge.
    task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
    endtask

    task automatic program_registers(input logic [23:0] sf, input logic [23:0] ss,
                                     input logic signed [15:0] cs,
                                     input logic signed [15:0] sn,
                                     input logic [23:0] ox, input logic [23:0] oy,
                                     input logic [12:0] gw, input logic [12:0] gh);
        // The block must be idle: wait for every outstanding transaction first.
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_register(REG_SCALE_FORWARD, sf);
        write_register(REG_SCALE_SIDE, ss);
        // Unused upper data bits carry noise; the block must ignore them.
        write_register(REG_COS_YAW, {8'($urandom), cs});
        write_register(REG_SIN_YAW, {8'($urandom), sn});
        write_register(REG_OFFSET_X, ox);
        write_register(REG_OFFSET_Y, oy);
        write_register(REG_GRID_WIDTH, {11'($urandom), gw});
        write_register(REG_GRID_HEIGHT, {11'($urandom), gh});
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        int gap;
        logic taken;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = !busy;
        end
        @(negedge clk);
    endtask

    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        longint gw;
        longint gh;
        longint sf;
        longint ss;
        longint cs;
        longint sn;
        longint ox;
        longint oy;
        int phase;
        int flavor;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        start     = 1'b0;
        pixel_col = '0;
        pixel_row = '0;
        idle_pct  = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero scales put every pixel on cell 0 of a 1x1 grid.
        send_pixel(10'd0, 9'd0);
        send_pixel(10'd1023, 9'd511);

        // Half a cell per pixel gives exact ties, on both sides of zero.
        program_registers(24'h008000, 24'h008000, 16'sd16384, 16'sd0, 24'd0, 24'd0,
                          13'd100, 13'd100);
        send_pixel(10'd320, 9'd479);
        send_pixel(10'd320, 9'd481);
        send_pixel(10'd321, 9'd480);
        send_pixel(10'd319, 9'd480);
        send_pixel(10'd639, 9'd0);
        send_pixel(10'd200, 9'd400);

        // Register extremes drive both coordinates into saturation.
        program_registers(24'hFFFFFF, 24'hFFFFFF, -16'sd16384, 16'sd16384, 24'h7FFFFF,
                          24'h800000, 13'd4096, 13'd4096);
        send_pixel(10'd0, 9'd0);
        send_pixel(10'd1023, 9'd511);
        send_pixel(10'd320, 9'd480);
        send_pixel(10'd639, 9'd479);

        // Grid wider than 4096: the flat index wraps to 24 bits.
        program_registers(24'h050000, 24'h010000, 16'sd16384, 16'sd0, 24'd0, 24'd0,
                          13'd8191, 13'd8191);
        send_pixel(10'd320, 9'd0);
        send_pixel(10'd1023, 9'd0);

        // Zero width with a quarter turn, then zero height.
        program_registers(24'h010000, 24'h010000, 16'sd0, -16'sd16384, 24'h000080,
                          24'hFFFF80, 13'd0, 13'd8191);
        send_pixel(10'd100, 9'd100);
        program_registers(24'h010000, 24'h010000, 16'sd16384, 16'sd0, 24'd0, 24'h014000,
                          13'd4096, 13'd0);
        send_pixel(10'd400, 9'd200);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            flavor = phase % 4;
            gw = $urandom_range(1) ? longint'($urandom_range(1, 100))
                                   : longint'($urandom_range(101, 4096));
            gh = $urandom_range(1) ? longint'($urandom_range(1, 100))
                                   : longint'($urandom_range(101, 4096));
            // Scales sized so that the region of interest roughly spans the grid.
            sf = gh * 65536 * longint'($urandom_range(50, 150)) / (ROI_H * 100);
            ss = gw * 65536 * longint'($urandom_range(50, 150)) / (ROI_W * 100);
            cs = 16384 - longint'($urandom_range(0, 1200));
            sn = longint'($urandom_range(0, 8000)) - 4000;
            ox = (longint'($urandom_range(0, gh / 2)) - gh / 4) * 256
                 + longint'($urandom_range(255));
            oy = (gw / 2 + longint'($urandom_range(0, gw / 2)) - gw / 4) * 256
                 + longint'($urandom_range(255));
            if (flavor == 1) begin
                // Facing backwards: the forward axis is folded back onto the grid.
                cs = -cs;
                ox = ox + gh * 256;
            end
            else if (flavor == 2) begin
                gw = $urandom_range(1) ? 0 : longint'($urandom_range(4097, 8191));
                gh = $urandom_range(1) ? 0 : longint'($urandom_range(4097, 8191));
            end
            if (flavor == 3)
                program_registers(24'($urandom), 24'($urandom), 16'($urandom),
                                  16'($urandom), 24'($urandom), 24'($urandom),
                                  13'($urandom), 13'($urandom));
            else
                program_registers(24'(sf), 24'(ss), 16'(cs), 16'(sn), 24'(ox), 24'(oy),
                                  13'(gw), 13'(gh));

            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 80;
                default: idle_pct = 11;
            endcase
            repeat (PHASE_PIXELS) begin
                if ($urandom_range(9) == 0)
                    send_pixel(10'($urandom), 9'($urandom));
                else
                    send_pixel(10'($urandom_range(ROI_W - 1)), 9'($urandom_range(ROI_H - 1)));
            end
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
